FILE: design/rhsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_pkg
// Types and constants shared by the RGB to HSV converter modules.
// ----------------------------------------------------------------------------
package rhsv_pkg;

  // Hue constants in 1/64 degree: 60, 120, 240 and 360 degrees.
  localparam int HUE_SCALE      = 3840;
  localparam int HUE_GREEN_BASE = 7680;
  localparam int HUE_BLUE_BASE  = 15360;
  localparam int HUE_FULL_TURN  = 23040;

  // Divider geometry: 24-bit numerators, 9-bit divisors, 15 quotient bits.
  localparam int NUM_W  = 24;
  localparam int DIV_W  = 9;
  localparam int QUO_W  = 15;
  localparam int STAGES = QUO_W + 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [12:0] saturation;
    logic [7:0]  brightness;
  } pixel_out_t;

  // One division lane: partial remainder and the word that shifts numerator
  // bits out at the top and quotient bits in at the bottom.
  typedef struct packed {
    logic [DIV_W-1:0] p;
    logic [QUO_W-1:0] w;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        hue;
    div_lane_t        sat;
    logic [DIV_W-1:0] hue_div;
    logic [DIV_W-1:0] sat_div;
    logic [7:0]       bright;
  } div_stage_t;

endpackage

FILE: design/rhsv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_front
// Finds max, min and delta, builds the rounded hue and saturation numerators.
// ----------------------------------------------------------------------------
module rhsv_front
  import rhsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  input  pixel_in_t  up_data,
  output logic       up_ready,
  output logic       dn_valid,
  output div_stage_t dn_data,
  input  logic       dn_ready
);

  logic             valid_r;
  div_stage_t       data_r;
  div_stage_t       data_nxt;

  logic [7:0]       r, g, b;
  logic [7:0]       mx, mn, d;
  logic             grey;
  logic [9:0]       sdiff;
  logic [14:0]      base;
  logic [24:0]      n_u;
  logic [NUM_W-1:0] hue_num, sat_num;

  always_comb begin
    r = up_data.red;
    g = up_data.green;
    b = up_data.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    grey = (d == 8'd0);

    // Sector select, ties go red, then green, then blue.
    if (mx == r) begin
      sdiff = {2'b0, g} - {2'b0, b};
      base  = (g < b) ? 15'(HUE_FULL_TURN) : 15'd0;
    end else if (mx == g) begin
      sdiff = {2'b0, b} - {2'b0, r};
      base  = 15'(HUE_GREEN_BASE);
    end else begin
      sdiff = {2'b0, r} - {2'b0, g};
      base  = 15'(HUE_BLUE_BASE);
    end

    // Signed offset done modulo 2^25; true value is non-negative and small.
    n_u = 25'(base) * 25'(d) + 25'(HUE_SCALE) * {{15{sdiff[9]}}, sdiff};
    hue_num = grey ? '0 : (NUM_W'({n_u[22:0], 1'b0}) + NUM_W'(d));
    sat_num = grey ? '0 : ({3'b0, d, 13'b0} + NUM_W'(mx));

    data_nxt.hue.p   = hue_num[NUM_W-1:QUO_W];
    data_nxt.hue.w   = hue_num[QUO_W-1:0];
    data_nxt.sat.p   = sat_num[NUM_W-1:QUO_W];
    data_nxt.sat.w   = sat_num[QUO_W-1:0];
    data_nxt.hue_div = grey ? DIV_W'(1) : {d, 1'b0};
    data_nxt.sat_div = grey ? DIV_W'(1) : {mx, 1'b0};
    data_nxt.bright  = mx;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: design/rhsv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_cell
// One restoring-division step for both hue and saturation lanes.
// ----------------------------------------------------------------------------
module rhsv_cell
  import rhsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  input  div_stage_t up_data,
  output logic       up_ready,
  output logic       dn_valid,
  output div_stage_t dn_data,
  input  logic       dn_ready
);

  logic       valid_r;
  div_stage_t data_r;
  div_stage_t data_nxt;

  function automatic div_lane_t step(input div_lane_t ln, input logic [DIV_W-1:0] dv);
    logic [DIV_W:0] t;
    logic           ge;
    div_lane_t      res;
    t  = {ln.p, ln.w[QUO_W-1]};
    ge = (t >= {1'b0, dv});
    res.p = ge ? DIV_W'(t - {1'b0, dv}) : t[DIV_W-1:0];
    res.w = {ln.w[QUO_W-2:0], ge};
    return res;
  endfunction

  always_comb begin
    data_nxt     = up_data;
    data_nxt.hue = step(up_data.hue, up_data.hue_div);
    data_nxt.sat = step(up_data.sat, up_data.sat_div);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: design/rgb_to_hsv_pixel_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_convert
// 8-bit RGB pixel to hue (1/64 degree), saturation (Q12) and value.
// ----------------------------------------------------------------------------
// Pipeline: the front stage registers the request, then fifteen division
//   cells register it in turn before out_valid.
// Throughput: one pixel per clock while out_stall is low; every stage holds
//   a request and advances it whenever the next stage is empty or moving.
// Reset: synchronous, active-low rst_n clears all stage valid bits;
//   payload registers are not reset.
module rgb_to_hsv_pixel_convert
  import rhsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  pixel_in_t  in_data,
  output logic       in_stall,
  output logic       out_valid,
  output pixel_out_t out_data,
  input  logic       out_stall
);

  // Stage 0 is the front; stages 1..QUO_W are the division cells.
  logic       stg_valid [STAGES];
  div_stage_t stg_data  [STAGES];
  logic       stg_ready [STAGES];  // ready of the stage to accept from upstream
  logic       in_ready;

  // Front: max/min/delta and the rounded numerators for both divisions.
  rhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_ready (in_ready),
    .dn_valid (stg_valid[0]),
    .dn_data  (stg_data[0]),
    .dn_ready (stg_ready[1])
  );

  assign in_stall     = !in_ready;
  assign stg_ready[0] = in_ready;

  // Chain of division cells; each resolves one hue and one saturation bit,
  // MSB first, and hands the lane word to its neighbor.
  for (genvar k = 1; k < STAGES; k++) begin : g_cell
    logic dn_rdy;
    if (k == STAGES - 1) begin : g_last
      assign dn_rdy = !out_stall;
    end else begin : g_mid
      assign dn_rdy = stg_ready[k+1];
    end

    rhsv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[k-1]),
      .up_data  (stg_data[k-1]),
      .up_ready (stg_ready[k]),
      .dn_valid (stg_valid[k]),
      .dn_data  (stg_data[k]),
      .dn_ready (dn_rdy)
    );
  end

  // The last cell's register is the output register; its words now hold
  // the finished quotients.
  assign out_valid           = stg_valid[STAGES-1];
  assign out_data.hue        = stg_data[STAGES-1].hue.w;
  assign out_data.saturation = stg_data[STAGES-1].sat.w[12:0];
  assign out_data.brightness = stg_data[STAGES-1].bright;

endmodule

FILE: design/rhsv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhsv_checker
  import rhsv_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input pixel_in_t  in_data,
  input logic       in_stall,
  input logic       out_valid,
  input pixel_out_t out_data,
  input logic       out_stall
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // No result is valid right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hue <= 15'd23039)
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.saturation <= 13'd4096)
    else $error("saturation out of range");

  // Zero saturation only for grey pixels, which carry zero hue.
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturation == 13'd0 |-> out_data.hue == 15'd0)
    else $error("grey result with nonzero hue");

endmodule

bind rgb_to_hsv_pixel_convert rhsv_checker u_rhsv_checker (.*);
